/* rtl/pic_pkg.sv */
package pic_pkg;

  localparam int PIC_NUM_SOURCES = 15;
  localparam int PIC_NUM_PINS    = 8;
  localparam int PIC_MAX_PINS    = 8;

  localparam int CMD_W   = 3;
  localparam int PIN_W   = 3;
  localparam int SRC_W   = 4;
  localparam int WDATA_W = 16;
  localparam int MASK_W  = 16;
  localparam int GPRI_W  = 8;
  localparam int MODES_W = 16;
  localparam int LEVEL_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIN_CHANGE = 3'd0,
    CMD_RAISE      = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_MASK       = 3'd3,
    CMD_STATUS     = 3'd4
  } cmd_t;

  localparam logic REG_GROUP_PRIO = 1'b0;
  localparam logic REG_PIN_MODES  = 1'b1;

  localparam logic [1:0] MODE_LEVEL = 2'd0;
  localparam logic [1:0] MODE_RISE  = 2'd2;
  localparam logic [1:0] MODE_BOTH  = 2'd3;

  localparam logic [GPRI_W-1:0]  GROUP_PRIO_RST = 8'he4;
  localparam logic [MODES_W-1:0] PIN_MODES_RST  = 16'haaaa;
  localparam logic [MASK_W-1:0]  MASK_RST       = 16'hffff;
  localparam logic [MASK_W-1:0]  MASK_WORD      = 16'h7fff;
  localparam logic [MASK_W-1:0]  MASK_HIGH      = 16'hff00;

  localparam logic [SRC_W-1:0] PIN_SRC [PIC_MAX_PINS] = '{
    4'd0, 4'd4, 4'd8, 4'd12, 4'd6, 4'd5, 4'd2, 4'd1
  };

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PIN_W-1:0]   pin;
    logic               pin_level;
    logic [SRC_W-1:0]   source;
    logic [WDATA_W-1:0] write_value;
    logic               low_byte_only;
  } item_t;

endpackage

/* rtl/pic_update.sv */
module pic_update
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES = PIC_NUM_SOURCES,
  parameter int NUM_PINS    = PIC_NUM_PINS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   apply,
  input  item_t                  item,
  input  logic [MODES_W-1:0]     pin_modes,
  output logic [NUM_SOURCES-1:0] pending_nxt,
  output logic [MASK_W-1:0]      mask_nxt
);

  logic [NUM_SOURCES-1:0] pending_r;
  logic [MASK_W-1:0]      mask_r;
  logic [NUM_PINS-1:0]    last_r;
  logic [NUM_PINS-1:0]    last_nxt;
  logic [NUM_SOURCES-1:0] set_vec;
  logic [NUM_SOURCES-1:0] clr_vec;
  logic [NUM_SOURCES-1:0] level_src;

  always_comb begin
    level_src = '0;
    for (int p = 0; p < NUM_PINS; p++) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        if (PIN_SRC[p] == SRC_W'(s) && pin_modes[2*p +: 2] == MODE_LEVEL) begin
          level_src[s] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [1:0] mode;
    logic       prev;
    logic       active;
    mode     = MODE_LEVEL;
    prev     = 1'b0;
    active   = 1'b0;
    set_vec  = '0;
    clr_vec  = '0;
    last_nxt = last_r;
    mask_nxt = mask_r;
    unique case (item.cmd)
      CMD_PIN_CHANGE: begin
        for (int p = 0; p < NUM_PINS; p++) begin
          if (item.pin == PIN_W'(p)) begin
            mode        = pin_modes[2*p +: 2];
            prev        = last_r[p];
            active      = (mode == MODE_BOTH) ? (item.pin_level != prev)
                                              : (item.pin_level && !prev);
            last_nxt[p] = item.pin_level;
            for (int s = 0; s < NUM_SOURCES; s++) begin
              if (PIN_SRC[p] == SRC_W'(s)) begin
                if (mode == MODE_LEVEL) begin
                  set_vec[s] = item.pin_level;
                  clr_vec[s] = !item.pin_level;
                end else if (active && (mode == MODE_RISE || mode == MODE_BOTH)) begin
                  set_vec[s] = 1'b1;
                end
              end
            end
          end
        end
      end
      CMD_RAISE: begin
        for (int s = 0; s < NUM_SOURCES; s++) begin
          if (item.source == SRC_W'(s)) begin
            set_vec[s] = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        clr_vec = item.write_value[NUM_SOURCES-1:0] & ~level_src;
      end
      CMD_MASK: begin
        if (item.low_byte_only) begin
          mask_nxt = (mask_r & MASK_HIGH) | (item.write_value & ~MASK_HIGH);
        end else begin
          mask_nxt = item.write_value & MASK_WORD;
        end
      end
      default: begin
      end
    endcase
    pending_nxt = (pending_r & ~clr_vec) | set_vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      mask_r    <= MASK_RST;
      last_r    <= '0;
    end else if (apply) begin
      pending_r <= pending_nxt;
      mask_r    <= mask_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

/* rtl/pic_resolve.sv */
module pic_resolve
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES = PIC_NUM_SOURCES
) (
  input  logic [NUM_SOURCES-1:0] pending,
  input  logic [MASK_W-1:0]      mask,
  input  logic [GPRI_W-1:0]      group_prio,
  output logic                   irq_request,
  output logic [LEVEL_W-1:0]     irq_level
);

  localparam int NUM_LEVELS = 1 << LEVEL_W;

  logic [NUM_SOURCES-1:0] live;
  logic [NUM_LEVELS-1:0]  hit;

  assign live = pending & ~mask[NUM_SOURCES-1:0];

  always_comb begin
    logic [LEVEL_W-1:0] prio;
    hit = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      prio = {group_prio[2*(s >> 2) +: 2], 2'(s & 3)};
      if (live[s]) begin
        hit[prio] = 1'b1;
      end
    end
  end

  always_comb begin
    irq_level = '0;
    for (int p = 0; p < NUM_LEVELS; p++) begin
      if (hit[p]) begin
        irq_level = LEVEL_W'(p);
      end
    end
  end

  assign irq_request = |live;

endmodule

/* rtl/priority_interrupt_controller.sv */
// Channel  Handshake            Payload
// in       in_valid / in_stall  cmd, pin, pin_level, source, write_value, low_byte_only
// out      out_valid / out_stall irq_request, irq_level, pending_bits, mask_bits
// cfg      cfg_we               cfg_index, cfg_wdata
//
// One beat is taken each cycle while in_stall is low; results pass input and output registers.
// The rate is set by the input register feeding one pass of state update and priority compare.
// Reset is synchronous and active low; it restores the state and register defaults.
// A stalled output holds its beat, and the input stalls only when both stages are full.
module priority_interrupt_controller
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES = PIC_NUM_SOURCES,
  parameter int NUM_PINS    = PIC_NUM_PINS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_W-1:0]       in_cmd,
  input  logic [PIN_W-1:0]       in_pin,
  input  logic                   in_pin_level,
  input  logic [SRC_W-1:0]       in_source,
  input  logic [WDATA_W-1:0]     in_write_value,
  input  logic                   in_low_byte_only,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_irq_request,
  output logic [LEVEL_W-1:0]     out_irq_level,
  output logic [NUM_SOURCES-1:0] out_pending_bits,
  output logic [MASK_W-1:0]      out_mask_bits,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [MODES_W-1:0]     cfg_wdata
);

  logic [GPRI_W-1:0]      group_prio_r;
  logic [MODES_W-1:0]     pin_modes_r;
  logic                   s1_valid_r;
  item_t                  s1_item_r;
  logic                   out_valid_r;
  logic                   out_req_r;
  logic [LEVEL_W-1:0]     out_level_r;
  logic [NUM_SOURCES-1:0] out_pending_r;
  logic [MASK_W-1:0]      out_mask_r;
  logic                   out_free;
  logic                   s1_adv;
  logic                   s1_load;
  logic [NUM_SOURCES-1:0] pending_nxt;
  logic [MASK_W-1:0]      mask_nxt;
  logic                   req_nxt;
  logic [LEVEL_W-1:0]     level_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_prio_r <= GROUP_PRIO_RST;
      pin_modes_r  <= PIN_MODES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_PRIO: group_prio_r <= cfg_wdata[GPRI_W-1:0];
        REG_PIN_MODES:  pin_modes_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= '{cmd: in_cmd, pin: in_pin, pin_level: in_pin_level,
                     source: in_source, write_value: in_write_value,
                     low_byte_only: in_low_byte_only};
    end
  end

  pic_update #(
    .NUM_SOURCES(NUM_SOURCES),
    .NUM_PINS   (NUM_PINS)
  ) u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .apply      (s1_adv),
    .item       (s1_item_r),
    .pin_modes  (pin_modes_r),
    .pending_nxt(pending_nxt),
    .mask_nxt   (mask_nxt)
  );

  pic_resolve #(
    .NUM_SOURCES(NUM_SOURCES)
  ) u_resolve (
    .pending    (pending_nxt),
    .mask       (mask_nxt),
    .group_prio (group_prio_r),
    .irq_request(req_nxt),
    .irq_level  (level_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_req_r     <= req_nxt;
      out_level_r   <= level_nxt;
      out_pending_r <= pending_nxt;
      out_mask_r    <= mask_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_irq_request  = out_req_r;
  assign out_irq_level    = out_level_r;
  assign out_pending_bits = out_pending_r;
  assign out_mask_bits    = out_mask_r;

`ifndef SYNTHESIS
  a_req_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_req_r == |(out_pending_r & ~out_mask_r[NUM_SOURCES-1:0])))
    else $error("Request does not match pending and mask bits.");

  a_level_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_req_r) |-> (out_level_r == '0))
    else $error("Level is not zero without a request.");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("Advanced beat did not reach the output.");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("Input stalled while a stage was free.");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pic_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BEATS   = 212;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic                       req;
    logic [LEVEL_W-1:0]         level;
    logic [PIC_NUM_SOURCES-1:0] pending;
    logic [MASK_W-1:0]          mask;
  } irq_status_t;

  typedef struct packed {
    logic        is_cfg;
    logic        cfg_idx;
    logic [15:0] cfg_val;
    item_t       beat;
    logic        typed;
    irq_status_t want;
  } stim_row_t;

  localparam item_t       NO_BEAT = '0;
  localparam irq_status_t NO_WANT = '0;
  localparam int          DIR_ROWS = 32;

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_STATUS, 3'd0, 1'b0, 4'd0, 16'h0000, 1'b0},
      1'b1, '{1'b0, 4'd0, 15'h0000, 16'hffff}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_RSVD_HI, 3'd7, 1'b1, 4'd15, 16'hffff, 1'b1},
      1'b1, '{1'b0, 4'd0, 15'h0000, 16'hffff}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_RSVD_LO, 3'd0, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b1, '{1'b0, 4'd0, 15'h0000, 16'hffff}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_RAISE, 3'd0, 1'b0, 4'd15, 16'h0000, 1'b0},
      1'b1, '{1'b0, 4'd0, 15'h0000, 16'hffff}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_RAISE, 3'd0, 1'b0, 4'd14, 16'h0000, 1'b0},
      1'b1, '{1'b0, 4'd0, 15'h4000, 16'hffff}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_MASK, 3'd0, 1'b0, 4'd0, 16'h0000, 1'b0},
      1'b1, '{1'b1, 4'd14, 15'h4000, 16'h0000}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_MASK, 3'd0, 1'b0, 4'd0, 16'hffff, 1'b0},
      1'b1, '{1'b0, 4'd0, 15'h4000, 16'h7fff}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_MASK, 3'd0, 1'b0, 4'd0, 16'hff00, 1'b1},
      1'b1, '{1'b0, 4'd0, 15'h4000, 16'h7f00}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_CLEAR, 3'd0, 1'b0, 4'd0, 16'hffff, 1'b0},
      1'b1, '{1'b0, 4'd0, 15'h0000, 16'h7f00}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_MASK, 3'd0, 1'b0, 4'd0, 16'h8000, 1'b0},
      1'b1, '{1'b0, 4'd0, 15'h0000, 16'h0000}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd0, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b1, '{1'b1, 4'd0, 15'h0001, 16'h0000}},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd0, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_RAISE, 3'd0, 1'b0, 4'd3, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd7, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd3, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b1, REG_GROUP_PRIO, 16'h0000, NO_BEAT, 1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_STATUS, 3'd0, 1'b0, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b1, REG_GROUP_PRIO, 16'h00ff, NO_BEAT, 1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_RAISE, 3'd0, 1'b0, 4'd13, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b1, REG_PIN_MODES, 16'h0000, NO_BEAT, 1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd0, 1'b0, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_CLEAR, 3'd0, 1'b0, 4'd0, 16'h7fff, 1'b0},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd4, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b1, REG_PIN_MODES, 16'hffff, NO_BEAT, 1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_CLEAR, 3'd0, 1'b0, 4'd0, 16'h0040, 1'b0},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd4, 1'b0, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b1, REG_PIN_MODES, 16'h5555, NO_BEAT, 1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd5, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b1, REG_PIN_MODES, 16'haaaa, NO_BEAT, 1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_PIN_CHANGE, 3'd5, 1'b1, 4'd0, 16'h0000, 1'b0},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_MASK, 3'd0, 1'b0, 4'd0, 16'habcd, 1'b1},
      1'b0, NO_WANT},
    '{1'b0, REG_GROUP_PRIO, 16'h0, '{CMD_MASK, 3'd0, 1'b0, 4'd0, 16'hffff, 1'b1},
      1'b0, NO_WANT}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [CMD_W-1:0]           in_cmd;
  logic [PIN_W-1:0]           in_pin;
  logic                       in_pin_level;
  logic [SRC_W-1:0]           in_source;
  logic [WDATA_W-1:0]         in_write_value;
  logic                       in_low_byte_only;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_irq_request;
  logic [LEVEL_W-1:0]         out_irq_level;
  logic [PIC_NUM_SOURCES-1:0] out_pending_bits;
  logic [MASK_W-1:0]          out_mask_bits;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [MODES_W-1:0]         cfg_wdata;

  logic [GPRI_W-1:0]          model_group_prio;
  logic [MODES_W-1:0]         model_pin_modes;
  logic [PIC_NUM_SOURCES-1:0] model_pending;
  logic [MASK_W-1:0]          model_mask;
  logic [PIC_MAX_PINS-1:0]    model_last_pin;

  irq_status_t status_q [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  priority_interrupt_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_pin           (in_pin),
    .in_pin_level     (in_pin_level),
    .in_source        (in_source),
    .in_write_value   (in_write_value),
    .in_low_byte_only (in_low_byte_only),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_irq_request  (out_irq_request),
    .out_irq_level    (out_irq_level),
    .out_pending_bits (out_pending_bits),
    .out_mask_bits    (out_mask_bits),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic irq_status_t irq_predict(item_t it);
    irq_status_t                res;
    logic [1:0]                 mode;
    logic [SRC_W-1:0]           tgt;
    logic [PIC_NUM_SOURCES-1:0] live;
    logic [3:0]                 prio;
    logic [3:0]                 best;
    bit                         found;
    bit                         level_src;
    best = '0;
    found = 1'b0;
    case (it.cmd)
      CMD_PIN_CHANGE: begin
        mode = model_pin_modes[2*it.pin +: 2];
        tgt = PIN_SRC[it.pin];
        if (mode == MODE_LEVEL) begin
          model_pending[tgt] = it.pin_level;
        end else if (mode == MODE_BOTH) begin
          if (it.pin_level != model_last_pin[it.pin]) model_pending[tgt] = 1'b1;
        end else if (mode == MODE_RISE) begin
          if (it.pin_level && !model_last_pin[it.pin]) model_pending[tgt] = 1'b1;
        end
        model_last_pin[it.pin] = it.pin_level;
      end
      CMD_RAISE: begin
        if (it.source < PIC_NUM_SOURCES) model_pending[it.source] = 1'b1;
      end
      CMD_CLEAR: begin
        for (int s = 0; s < PIC_NUM_SOURCES; s++) begin
          level_src = 1'b0;
          for (int p = 0; p < PIC_NUM_PINS; p++) begin
            if (PIN_SRC[p] == s && model_pin_modes[2*p +: 2] == MODE_LEVEL) level_src = 1'b1;
          end
          if (it.write_value[s] && !level_src) model_pending[s] = 1'b0;
        end
      end
      CMD_MASK: begin
        if (it.low_byte_only) begin
          model_mask = (model_mask & MASK_HIGH) | {8'h00, it.write_value[7:0]};
        end else begin
          model_mask = it.write_value & MASK_WORD;
        end
      end
      default: begin
      end
    endcase
    live = model_pending & ~model_mask[PIC_NUM_SOURCES-1:0];
    for (int s = 0; s < PIC_NUM_SOURCES; s++) begin
      if (live[s]) begin
        prio = {model_group_prio[2*(s/4) +: 2], 2'(s)};
        if (!found || prio > best) begin
          best = prio;
          found = 1'b1;
        end
      end
    end
    res.req = found;
    res.level = found ? best : 4'd0;
    res.pending = model_pending;
    res.mask = model_mask;
    return res;
  endfunction

  task automatic send_beat(item_t it, bit typed, irq_status_t want);
    irq_status_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= it.cmd;
    in_pin           <= it.pin;
    in_pin_level     <= it.pin_level;
    in_source        <= it.source;
    in_write_value   <= it.write_value;
    in_low_byte_only <= it.low_byte_only;
    do @(posedge clk); while (in_stall);
    pred = irq_predict(it);
    status_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [MODES_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_GROUP_PRIO) begin
      model_group_prio = val[GPRI_W-1:0];
    end else begin
      model_pin_modes = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : status_check
    irq_status_t got;
    irq_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_irq_request, out_irq_level, out_pending_bits, out_mask_bits};
      if (status_q.size() == 0) begin
        $display("%0t: unexpected status beat req=%0d level=%0d pending=%h mask=%h",
                 $time, got.req, got.level, got.pending, got.mask);
        error_count++;
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          $display("%0t: status mismatch: expected req=%0d level=%0d pending=%h mask=%h",
                   $time, want.req, want.level, want.pending, want.mask);
          $display("%0t:                  actual   req=%0d level=%0d pending=%h mask=%h",
                   $time, got.req, got.level, got.pending, got.mask);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("priority_interrupt_controller regression: fail");
    $finish;
  end

  initial begin
    item_t             it;
    int                pick;
    logic [GPRI_W-1:0] gp;
    logic [MODES_W-1:0] modes;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = '0;
    in_pin           = '0;
    in_pin_level     = 1'b0;
    in_source        = '0;
    in_write_value   = '0;
    in_low_byte_only = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_GROUP_PRIO;
    cfg_wdata        = '0;
    model_group_prio = GROUP_PRIO_RST;
    model_pin_modes  = PIN_MODES_RST;
    model_pending    = '0;
    model_mask       = MASK_RST;
    model_last_pin   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].is_cfg) begin
        write_reg(DIRECTED[i].cfg_idx, DIRECTED[i].cfg_val);
      end else begin
        send_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          gp = 8'h00;
          modes = 16'h0000;
        end
        1: begin
          gp = 8'hff;
          modes = 16'hffff;
        end
        2: begin
          gp = GROUP_PRIO_RST;
          modes = PIN_MODES_RST;
        end
        3: begin
          gp = 8'h1b;
          modes = 16'h5555;
        end
        default: begin
          gp = 8'($urandom);
          modes = 16'($urandom);
        end
      endcase
      write_reg(REG_GROUP_PRIO, 16'(gp));
      write_reg(REG_PIN_MODES, modes);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 0 && n == PHASE_BEATS / 2) hold_request = 1'b1;
        pick = $urandom_range(99);
        if (pick < 35) it.cmd = CMD_PIN_CHANGE;
        else if (pick < 55) it.cmd = CMD_RAISE;
        else if (pick < 70) it.cmd = CMD_CLEAR;
        else if (pick < 85) it.cmd = CMD_MASK;
        else if (pick < 95) it.cmd = CMD_STATUS;
        else it.cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        it.pin = 3'($urandom_range(7));
        it.pin_level = 1'($urandom_range(1));
        it.source = ($urandom_range(15) == 0) ? 4'd15 : 4'($urandom_range(14));
        it.write_value = ($urandom_range(3) == 0) ? (16'h1 << $urandom_range(15))
                                                  : 16'($urandom);
        it.low_byte_only = 1'($urandom_range(1));
        send_beat(it, 1'b0, NO_WANT);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("priority_interrupt_controller regression: pass");
    end else begin
      $display("priority_interrupt_controller regression: fail");
    end
    $finish;
  end

endmodule
